FILE: rtl/modbus_rtu_frame_receiver_core_macros.svh
// Assertion macros for the Modbus RTU frame receiver.
// Included by the receiver core, which checks its own logic; no other dependencies.
`ifndef MODBUS_RTU_FRAME_RECEIVER_CORE_MACROS_SVH
`define MODBUS_RTU_FRAME_RECEIVER_CORE_MACROS_SVH

// same-cycle implication
`define MRTU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MRTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mrtu_pkg.sv
// Shared types, constants and the CRC-16 step for the Modbus RTU frame receiver.
// No dependencies.
package mrtu_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;
    localparam int DATA_W           = 8;
    localparam int IDX_W            = 6;
    localparam int ST_W             = 3;
    localparam int CMD_W            = 2;
    localparam int TICK_W           = 16;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;
    localparam int EXC_BIT_POS      = 7;

    localparam logic [15:0]       CRC_INIT   = 16'hFFFF;
    localparam logic [15:0]       CRC_POLY   = 16'hA001;
    localparam logic [TICK_W-1:0] GAP_RESET  = 16'd30;
    localparam logic [TICK_W-1:0] RESP_RESET = 16'd1000;
    localparam logic [TICK_W-1:0] TICK_MAX   = 16'hFFFF;

    localparam logic REG_GAP_TICKS      = 1'b0;
    localparam logic REG_RESPONSE_TICKS = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE     = 2'd0,
        CMD_TICK     = 2'd1,
        CMD_LINE_ERR = 2'd2,
        CMD_ARM      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_ADDR = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 3'd0,
        ST_NORESP = 3'd1,
        ST_CRC    = 3'd2,
        ST_EXC    = 3'd3,
        ST_LINE   = 3'd4,
        ST_SHORT  = 3'd5,
        ST_OVF    = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        RS_COLLECT = 2'd0,
        RS_READ    = 2'd1,
        RS_LOAD    = 2'd2,
        RS_STAT    = 2'd3
    } t_rd_state;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc,
                                               input logic [DATA_W-1:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/mrtu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/modbus_rtu_frame_receiver_core.sv
// Modbus RTU response receiver: byte collection, CRC-16, gap timing, frame readout.
// Uses mrtu_pkg, mrtu_ram and the assertion macro header.
// Input requests are taken while collecting and the output register is free; a no-response
// item or a frame's readout starts in the cycle after the tick that causes it. In readout,
// each byte passes the store read port, then the output register; a status item follows.
// Synchronous active-low reset: idle, registers at defaults; data store is not cleared.
`include "modbus_rtu_frame_receiver_core_macros.svh"

module modbus_rtu_frame_receiver_core #(
    parameter int BUFFER_DEPTH = mrtu_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [mrtu_pkg::CMD_W-1:0]   i_cmd,
    input  logic [mrtu_pkg::DATA_W-1:0]  i_rx_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mrtu_pkg::DATA_W-1:0]  o_data_byte,
    output logic [mrtu_pkg::IDX_W-1:0]   o_byte_index,
    output logic [mrtu_pkg::ST_W-1:0]    o_status,
    output logic [mrtu_pkg::DATA_W-1:0]  o_slave_address,
    output logic [mrtu_pkg::DATA_W-1:0]  o_function_code,
    output logic [mrtu_pkg::IDX_W-1:0]   o_payload_len,
    output logic [mrtu_pkg::DATA_W-1:0]  o_exception_code,
    output logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrtu_pkg::PADDR_W-1:0] paddr,
    input  logic [mrtu_pkg::PDATA_W-1:0] pwdata,
    output logic [mrtu_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import mrtu_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL  = CW'(BUFFER_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_DEPTH - 1);

    // configuration
    logic [TICK_W-1:0] r_gap_ticks;
    logic [TICK_W-1:0] r_resp_ticks;
    logic              cfg_wr;

    // frame state
    t_phase            r_phase, n_phase;
    logic [15:0]       r_crc, n_crc;
    logic [DATA_W-1:0] r_addr, n_addr;
    logic [DATA_W-1:0] r_func, n_func;
    logic [DATA_W-1:0] r_first, n_first;
    logic [CW-1:0]     r_count, n_count;
    logic [TICK_W-1:0] r_gap_cnt, n_gap_cnt;
    logic [TICK_W-1:0] r_wait_cnt, n_wait_cnt;
    logic              r_line_err, n_line_err;
    logic              r_ovf, n_ovf;

    // readout
    t_rd_state         r_rd_state, n_rd_state;
    logic [AW-1:0]     r_rd_idx, n_rd_idx;
    t_status           r_run_st, n_run_st;
    logic [IDX_W-1:0]  r_plen, n_plen;
    logic [DATA_W-1:0] r_exc, n_exc;

    // output register
    logic              r_o_valid, n_o_valid;
    logic [DATA_W-1:0] r_o_data, n_o_data;
    logic [IDX_W-1:0]  r_o_idx, n_o_idx;
    t_status           r_o_st, n_o_st;
    logic [DATA_W-1:0] r_o_addr, n_o_addr;
    logic [DATA_W-1:0] r_o_func, n_o_func;
    logic [IDX_W-1:0]  r_o_plen, n_o_plen;
    logic [DATA_W-1:0] r_o_exc, n_o_exc;
    logic              r_o_last, n_o_last;

    // data store ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;

    logic              out_free;
    logic              in_acc;
    logic [TICK_W-1:0] tick_cnt;
    logic [IDX_W-1:0]  fin_plen;
    t_status           fin_st;

    assign out_free = !r_o_valid || i_ready;
    assign o_ready  = (r_rd_state == RS_COLLECT) && out_free;
    assign in_acc   = i_valid && o_ready;

    mrtu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_GAP_TICKS:      prdata = {16'h0000, r_gap_ticks};
            REG_RESPONSE_TICKS: prdata = {16'h0000, r_resp_ticks};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ticks  <= GAP_RESET;
            r_resp_ticks <= RESP_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_GAP_TICKS:      r_gap_ticks  <= pwdata[TICK_W-1:0];
                REG_RESPONSE_TICKS: r_resp_ticks <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // frame end summary
    always_comb begin
        fin_plen = '0;
        if (r_phase == PH_DATA && r_count >= CW'(2)) begin
            fin_plen = IDX_W'(r_count) - IDX_W'(2);
        end
        priority if (r_line_err) begin
            fin_st = ST_LINE;
        end else if (r_ovf) begin
            fin_st = ST_OVF;
        end else if (r_phase != PH_DATA || r_count < CW'(2)) begin
            fin_st = ST_SHORT;
        end else if (r_crc != 16'h0000) begin
            fin_st = ST_CRC;
        end else if (r_func[EXC_BIT_POS]) begin
            fin_st = ST_EXC;
        end else begin
            fin_st = ST_OK;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_crc      = r_crc;
        n_addr     = r_addr;
        n_func     = r_func;
        n_first    = r_first;
        n_count    = r_count;
        n_gap_cnt  = r_gap_cnt;
        n_wait_cnt = r_wait_cnt;
        n_line_err = r_line_err;
        n_ovf      = r_ovf;
        n_rd_state = r_rd_state;
        n_rd_idx   = r_rd_idx;
        n_run_st   = r_run_st;
        n_plen     = r_plen;
        n_exc      = r_exc;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_data   = r_o_data;
        n_o_idx    = r_o_idx;
        n_o_st     = r_o_st;
        n_o_addr   = r_o_addr;
        n_o_func   = r_o_func;
        n_o_plen   = r_o_plen;
        n_o_exc    = r_o_exc;
        n_o_last   = r_o_last;
        ram_we     = 1'b0;
        ram_waddr  = r_count[AW-1:0];
        ram_re     = 1'b0;
        tick_cnt   = '0;

        unique case (r_rd_state)
            RS_COLLECT: begin
                if (in_acc) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_BYTE: begin
                            if (r_phase != PH_IDLE) begin
                                n_crc     = crc16_feed(r_crc, i_rx_byte);
                                n_gap_cnt = '0;
                                unique case (r_phase)
                                    PH_WAIT: begin
                                        n_addr  = i_rx_byte;
                                        n_phase = PH_ADDR;
                                    end
                                    PH_ADDR: begin
                                        n_func  = i_rx_byte;
                                        n_phase = PH_DATA;
                                    end
                                    default: begin
                                        ram_we = 1'b1;
                                        if (r_count == '0) begin
                                            n_first = i_rx_byte;
                                        end
                                        if (r_count >= CNT_FULL) begin
                                            n_ovf     = 1'b1;
                                            ram_waddr = LAST_SLOT;
                                        end else begin
                                            n_count = r_count + CW'(1);
                                        end
                                    end
                                endcase
                            end
                        end
                        CMD_TICK: begin
                            if (r_phase == PH_WAIT) begin
                                tick_cnt = (r_wait_cnt != TICK_MAX) ?
                                           r_wait_cnt + TICK_W'(1) : r_wait_cnt;
                                n_wait_cnt = tick_cnt;
                                if (tick_cnt >= r_resp_ticks) begin
                                    n_phase   = PH_IDLE;
                                    n_o_valid = 1'b1;
                                    n_o_data  = '0;
                                    n_o_idx   = '0;
                                    n_o_st    = ST_NORESP;
                                    n_o_addr  = '0;
                                    n_o_func  = '0;
                                    n_o_plen  = '0;
                                    n_o_exc   = '0;
                                    n_o_last  = 1'b1;
                                end
                            end else if (r_phase != PH_IDLE) begin
                                tick_cnt = (r_gap_cnt != TICK_MAX) ?
                                           r_gap_cnt + TICK_W'(1) : r_gap_cnt;
                                n_gap_cnt = tick_cnt;
                                if (tick_cnt >= r_gap_ticks) begin
                                    n_phase  = PH_IDLE;
                                    n_run_st = fin_st;
                                    n_plen   = fin_plen;
                                    n_exc    = (r_func[EXC_BIT_POS] && fin_plen != '0) ?
                                               r_first : '0;
                                    n_rd_idx = '0;
                                    n_rd_state = (fin_plen != '0) ? RS_READ : RS_STAT;
                                end
                            end
                        end
                        CMD_LINE_ERR: begin
                            if (r_phase != PH_IDLE) begin
                                n_line_err = 1'b1;
                            end
                        end
                        CMD_ARM: begin
                            n_crc      = CRC_INIT;
                            n_addr     = '0;
                            n_func     = '0;
                            n_count    = '0;
                            n_gap_cnt  = '0;
                            n_wait_cnt = '0;
                            n_line_err = 1'b0;
                            n_ovf      = 1'b0;
                            n_phase    = PH_WAIT;
                        end
                    endcase
                end
            end
            RS_READ: begin
                // store writes only happen while collecting, so no overlap here
                ram_re     = 1'b1;
                n_rd_state = RS_LOAD;
            end
            RS_LOAD: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_data  = ram_rdata;
                    n_o_idx   = IDX_W'(r_rd_idx);
                    n_o_st    = r_run_st;
                    n_o_addr  = r_addr;
                    n_o_func  = r_func;
                    n_o_plen  = r_plen;
                    n_o_exc   = r_exc;
                    n_o_last  = 1'b0;
                    if (IDX_W'(r_rd_idx) + IDX_W'(1) < r_plen) begin
                        n_rd_idx   = r_rd_idx + AW'(1);
                        n_rd_state = RS_READ;
                    end else begin
                        n_rd_state = RS_STAT;
                    end
                end
            end
            RS_STAT: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_data   = '0;
                    n_o_idx    = '0;
                    n_o_st     = r_run_st;
                    n_o_addr   = r_addr;
                    n_o_func   = r_func;
                    n_o_plen   = r_plen;
                    n_o_exc    = r_exc;
                    n_o_last   = 1'b1;
                    n_rd_state = RS_COLLECT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_crc      <= CRC_INIT;
            r_addr     <= '0;
            r_func     <= '0;
            r_count    <= '0;
            r_gap_cnt  <= '0;
            r_wait_cnt <= '0;
            r_line_err <= 1'b0;
            r_ovf      <= 1'b0;
            r_rd_state <= RS_COLLECT;
            r_rd_idx   <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_crc      <= n_crc;
            r_addr     <= n_addr;
            r_func     <= n_func;
            r_count    <= n_count;
            r_gap_cnt  <= n_gap_cnt;
            r_wait_cnt <= n_wait_cnt;
            r_line_err <= n_line_err;
            r_ovf      <= n_ovf;
            r_rd_state <= n_rd_state;
            r_rd_idx   <= n_rd_idx;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_run_st <= n_run_st;
        r_plen   <= n_plen;
        r_exc    <= n_exc;
        r_o_data <= n_o_data;
        r_o_idx  <= n_o_idx;
        r_o_st   <= n_o_st;
        r_o_addr <= n_o_addr;
        r_o_func <= n_o_func;
        r_o_plen <= n_o_plen;
        r_o_exc  <= n_o_exc;
        r_o_last <= n_o_last;
    end

    assign o_valid          = r_o_valid;
    assign o_data_byte      = r_o_data;
    assign o_byte_index     = r_o_idx;
    assign o_status         = r_o_st;
    assign o_slave_address  = r_o_addr;
    assign o_function_code  = r_o_func;
    assign o_payload_len    = r_o_plen;
    assign o_exception_code = r_o_exc;
    assign o_last           = r_o_last;

    `MRTU_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL,
        "data count beyond store depth")
    `MRTU_ASSERT_NOW(a_ovf_full, i_clk, i_rst_n, r_ovf, r_count == CNT_FULL,
        "overflow flagged with store not full")
    `MRTU_ASSERT_NOW(a_idx_in_run, i_clk, i_rst_n, r_o_valid && !r_o_last,
        r_o_idx < r_o_plen, "payload index outside payload length")
    `MRTU_ASSERT_NOW(a_noresp_last, i_clk, i_rst_n, r_o_valid && r_o_st == ST_NORESP,
        r_o_last && r_o_plen == '0, "no-response item malformed")
    `MRTU_ASSERT_NEXT(a_arm_wait, i_clk, i_rst_n, in_acc && i_cmd == CMD_ARM,
        r_phase == PH_WAIT && r_rd_state == RS_COLLECT, "arm did not enter response wait")

endmodule
